FILE: hw/rtl/hsv_box_color_classifier_assert.svh
// Assertion macros shared by the checker files.
`ifndef HSV_BOX_COLOR_CLASSIFIER_ASSERT_SVH
`define HSV_BOX_COLOR_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HBCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HBCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/hbcc_pkg.sv
// ----------------------------------------------------------------------------
// HSV box classifier package
// Box layout, tally type, class codes and the per-point and per-object
// functions shared by the classifier modules.
// ----------------------------------------------------------------------------
package hbcc_pkg;

   localparam int unsigned NUM_BOXES  = 6;
   localparam int unsigned MAX_POINTS = 65535;

   localparam logic [15:0] COUNT_CAP =
      (MAX_POINTS > 65535) ? 16'hFFFF : 16'(MAX_POINTS);

   localparam int unsigned BOX_RED    = 0;
   localparam int unsigned BOX_BLUE   = 1;
   localparam int unsigned BOX_GREEN  = 2;
   localparam int unsigned BOX_YELLOW = 3;
   localparam int unsigned BOX_ORANGE = 4;
   localparam int unsigned BOX_PURPLE = 5;

   localparam logic [2:0] CLASS_NONE   = 3'd0;
   localparam logic [2:0] CLASS_RED    = 3'd1;
   localparam logic [2:0] CLASS_BLUE   = 3'd2;
   localparam logic [2:0] CLASS_GREEN  = 3'd3;
   localparam logic [2:0] CLASS_YELLOW = 3'd4;
   localparam logic [2:0] CLASS_ORANGE = 3'd5;
   localparam logic [2:0] CLASS_PURPLE = 3'd6;

   typedef struct packed {
      logic [7:0] val_max;
      logic [7:0] val_min;
      logic [7:0] sat_max;
      logic [7:0] sat_min;
      logic [8:0] hue_max;
      logic [8:0] hue_min;
   } box_type;

   typedef logic [15:0] count_type;

   typedef struct packed {
      count_type [NUM_BOXES-1:0] box;
      count_type                 total;
   } tally_type;

   function automatic logic in_box(box_type b, logic [8:0] hue, logic [7:0] sat,
                                   logic [7:0] bri);
      return (hue > b.hue_min) && (hue < b.hue_max) &&
             (sat > b.sat_min) && (sat < b.sat_max) &&
             (bri > b.val_min) && (bri < b.val_max);
   endfunction

   function automatic count_type sat_inc(count_type v);
      return (v < COUNT_CAP) ? v + 16'd1 : COUNT_CAP;
   endfunction

   // 4*count > total, on 18 bits
   function automatic logic over_quarter(count_type c, count_type t);
      return {c, 2'b00} > {2'b00, t};
   endfunction

   function automatic logic [2:0] pick_class(tally_type tl);
      logic [2:0] cls;
      count_type  r;
      count_type  y;
      r = tl.box[BOX_RED];
      y = tl.box[BOX_YELLOW];
      priority if (over_quarter(r, tl.total) && r > y) begin
         cls = CLASS_RED;
      end else if ({tl.box[BOX_BLUE], 1'b0} > {1'b0, tl.total}) begin
         cls = CLASS_BLUE;
      end else if (over_quarter(tl.box[BOX_GREEN], tl.total)) begin
         cls = CLASS_GREEN;
      end else if (over_quarter(y, tl.total) && y > r) begin
         cls = CLASS_YELLOW;
      end else if (over_quarter(tl.box[BOX_ORANGE], tl.total) &&
                   tl.box[BOX_ORANGE] > r) begin
         cls = CLASS_ORANGE;
      end else if (over_quarter(tl.box[BOX_PURPLE], tl.total) &&
                   tl.box[BOX_PURPLE] > r) begin
         cls = CLASS_PURPLE;
      end else begin
         cls = CLASS_NONE;
      end
      return cls;
   endfunction

endpackage

FILE: hw/rtl/hbcc_csr.sv
// ----------------------------------------------------------------------------
// HSV box classifier register file
// APB-style access to the six packed color box registers.
// ----------------------------------------------------------------------------
module hbcc_csr
   import hbcc_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [5:0]                     paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready,
   output box_type [NUM_BOXES-1:0]        boxes
);

   box_type [NUM_BOXES-1:0] boxes_ff;
   box_type [NUM_BOXES-1:0] boxes_in;
   logic    [2:0]           index;
   logic                    index_ok;

   assign index    = paddr[5:3];
   assign index_ok = index < 3'(NUM_BOXES);
   assign pready   = 1'b1;
   assign boxes    = boxes_ff;

   always_comb begin
      boxes_in = boxes_ff;
      if (psel && penable && pwrite && index_ok) begin
         boxes_in[index] = pwdata[$bits(box_type)-1:0];
      end
   end

   always_comb begin
      prdata = 64'd0;
      if (index_ok) begin
         prdata = 64'(boxes_ff[index]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boxes_ff <= '0;
      end else begin
         boxes_ff <= boxes_in;
      end
   end

endmodule

FILE: hw/rtl/hbcc_front.sv
// ----------------------------------------------------------------------------
// HSV box classifier front end
// Accepts points, tests them against the boxes and keeps the running
// tallies; hands a finished tally to the queue on the last point.
// ----------------------------------------------------------------------------
module hbcc_front
   import hbcc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [8:0]              hue,
   input  logic [7:0]              saturation,
   input  logic [7:0]              brightness,
   input  logic                    last_point,
   input  box_type [NUM_BOXES-1:0] boxes,
   input  logic                    q_full,
   output logic                    q_push,
   output tally_type               q_data
);

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [NUM_BOXES-1:0]          s1_match_ff;
   logic                          s1_last_ff;
   logic [NUM_BOXES-1:0]          match;
   tally_type                     tally_ff;
   tally_type                     tally_in;
   tally_type                     tally_next;
   logic                          advance;
   logic                          accept;

   assign advance = s1_valid_ff && !(s1_last_ff && q_full);
   assign full    = s1_valid_ff && !advance;
   assign accept  = push && !full;

   always_comb begin
      for (int i = 0; i < NUM_BOXES; i++) begin
         match[i] = in_box(boxes[i], hue, saturation, brightness);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_BOXES; i++) begin
         tally_next.box[i] = s1_match_ff[i] ? sat_inc(tally_ff.box[i]) : tally_ff.box[i];
      end
      tally_next.total = sat_inc(tally_ff.total);
   end

   assign q_push = advance && s1_last_ff;
   assign q_data = tally_next;

   always_comb begin
      tally_in = tally_ff;
      if (advance) begin
         tally_in = s1_last_ff ? '0 : tally_next;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         tally_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         tally_ff    <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_match_ff <= match;
         s1_last_ff  <= last_point;
      end
   end

endmodule

FILE: hw/rtl/hbcc_queue.sv
// ----------------------------------------------------------------------------
// HSV box classifier tally queue
// Small register queue of finished tallies between front and back end.
// ----------------------------------------------------------------------------
module hbcc_queue
   import hbcc_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  tally_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output tally_type rd_data,
   output logic      empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tally_type [DEPTH-1:0] entries_ff;
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hw/rtl/hbcc_back.sv
// ----------------------------------------------------------------------------
// HSV box classifier back end
// Picks the color class of the oldest tally and holds it in the result
// register until taken.
// ----------------------------------------------------------------------------
module hbcc_back
   import hbcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  tally_type  q_head,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output logic [2:0] color_class,
   output tally_type  tally
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic [2:0] class_ff;
   tally_type  tally_ff;
   logic       load;

   assign load         = !q_empty && (!out_valid_ff || pop);
   assign q_pop        = load;
   assign out_valid_in = load ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   assign empty        = !out_valid_ff;
   assign color_class  = class_ff;
   assign tally        = tally_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         class_ff <= pick_class(q_head);
         tally_ff <= q_head;
      end
   end

endmodule

FILE: hw/rtl/hsv_box_color_classifier.sv
// ----------------------------------------------------------------------------
// HSV box color classifier
// Counts the points of one object that fall in each of six HSV boxes and
// reports the counts and a color class on the object's last point.
//
//   channel   ports          handshake             moves
//   points    req_*          push / full           one HSV point
//   results   rsp_*          empty / pop           class and counts
//   config    p*             psel/penable/pwrite   one 50-bit box register
//
// One point is taken every cycle while full is low. A result passes through the
// match register, the tally queue and the result register on its way to
// rsp_*. The tally queue holds QUEUE_DEPTH results; full rises only while a
// last point waits for room in it. Reset clears the counters, the queue and
// the box registers.
// ----------------------------------------------------------------------------
module hsv_box_color_classifier
   import hbcc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [8:0]  req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   input  logic        req_last_point,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_color_class,
   output logic [15:0] rsp_red_count,
   output logic [15:0] rsp_blue_count,
   output logic [15:0] rsp_green_count,
   output logic [15:0] rsp_yellow_count,
   output logic [15:0] rsp_orange_count,
   output logic [15:0] rsp_purple_count,
   output logic [15:0] rsp_total_points,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);

   box_type [NUM_BOXES-1:0] boxes;
   logic                    q_full;
   logic                    q_empty;
   logic                    q_push;
   logic                    q_pop;
   tally_type               q_wr_data;
   tally_type               q_head;
   tally_type               out_tally;

   hbcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .boxes   (boxes)
   );

   hbcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .last_point (req_last_point),
      .boxes      (boxes),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wr_data)
   );

   hbcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   hbcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .pop         (pop),
      .empty       (empty),
      .color_class (rsp_color_class),
      .tally       (out_tally)
   );

   assign rsp_red_count    = out_tally.box[BOX_RED];
   assign rsp_blue_count   = out_tally.box[BOX_BLUE];
   assign rsp_green_count  = out_tally.box[BOX_GREEN];
   assign rsp_yellow_count = out_tally.box[BOX_YELLOW];
   assign rsp_orange_count = out_tally.box[BOX_ORANGE];
   assign rsp_purple_count = out_tally.box[BOX_PURPLE];
   assign rsp_total_points = out_tally.total;

endmodule

FILE: hw/rtl/hbcc_checker.sv
// ----------------------------------------------------------------------------
// HSV box classifier checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsv_box_color_classifier_assert.svh"

module hbcc_checker
   import hbcc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [2:0]  rsp_color_class,
   input logic [15:0] rsp_red_count,
   input logic [15:0] rsp_blue_count,
   input logic [15:0] rsp_green_count,
   input logic [15:0] rsp_yellow_count,
   input logic [15:0] rsp_orange_count,
   input logic [15:0] rsp_purple_count,
   input logic [15:0] rsp_total_points
);

   logic         is_red;
   logic         red_ok;
   logic         counts_ok;
   logic         total_ok;
   logic         rsp_wait;
   logic [115:0] rsp_word;
   logic [17:0]  red_x4;
   logic [17:0]  total_x1;

   assign red_x4   = {rsp_red_count, 2'b00};
   assign total_x1 = {2'b00, rsp_total_points};
   assign is_red   = !empty && (rsp_color_class == CLASS_RED);
   assign red_ok   = (red_x4 > total_x1) && (rsp_red_count > rsp_yellow_count);
   assign total_ok = rsp_total_points != 16'd0;
   assign rsp_wait = !empty && !pop;

   // empty rides along, so a stable word also means the transaction stays offered
   assign rsp_word = {empty, rsp_color_class, rsp_red_count, rsp_blue_count,
                      rsp_green_count, rsp_yellow_count, rsp_orange_count,
                      rsp_purple_count, rsp_total_points};

   assign counts_ok = (rsp_red_count    <= rsp_total_points) &&
                      (rsp_blue_count   <= rsp_total_points) &&
                      (rsp_green_count  <= rsp_total_points) &&
                      (rsp_yellow_count <= rsp_total_points) &&
                      (rsp_orange_count <= rsp_total_points) &&
                      (rsp_purple_count <= rsp_total_points);

   `HBCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_word), "stall not held")
   `HBCC_ASSERT_NOW(a_total_nonzero, clock, reset, !empty, total_ok, "result with zero points")
   `HBCC_ASSERT_NOW(a_counts_bounded, clock, reset, !empty, counts_ok, "box count above total")
   `HBCC_ASSERT_NOW(a_red_rule, clock, reset, is_red, red_ok, "red class without red majority")

endmodule

bind hsv_box_color_classifier hbcc_checker u_checker (.*);
